FILE: rtl/pis_pkg.sv
package pis_pkg;

  // Operand widths of the shared arithmetic unit.
  localparam int MUL_W  = 64;   // multiplier and multiplicand
  localparam int DEN_W  = 96;   // divisor, widest is n*(n-1)
  localparam int RAD_W  = 112;  // square root radicand
  localparam int ROOT_W = 56;   // square root result

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    start;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP,
    ST_SQ,
    ST_ACC,
    ST_CHECK,
    ST_MEAN,
    ST_SUMSQ,
    ST_NSQ,
    ST_NN,
    ST_VAR,
    ST_ROOT,
    ST_CV,
    ST_EMIT
  } pis_state_t;

endpackage

FILE: rtl/pis_alu.sv
module pis_alu #(
  parameter int RES_W = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pis_pkg::alu_ctl_t         ctl,
  input  logic [RES_W-1:0]          opa,
  input  logic [pis_pkg::DEN_W-1:0] opb,
  output logic                      done,
  output logic [RES_W-1:0]          res
);

  localparam int CNT_W = $clog2(RES_W);
  localparam int DW    = pis_pkg::DEN_W;
  localparam int MW    = pis_pkg::MUL_W;
  localparam int RW    = pis_pkg::ROOT_W;
  localparam int AW    = pis_pkg::RAD_W;

  pis_pkg::alu_op_t op_r;
  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_last;
  logic [RES_W-1:0] work;
  logic [DW:0]      rem;
  logic [DW-1:0]    opb_r;

  logic [DW:0]      div_sh;
  logic             div_ge;
  logic [DW:0]      div_rem;
  logic [MW:0]      mul_sum;
  logic [RW+1:0]    sq_sh;
  logic [RW+1:0]    sq_trial;
  logic             sq_ge;
  logic [RW+1:0]    sq_rem;

  // One step of each operation: restoring division, shift-add multiply and
  // digit-by-digit square root. Only the step of the active operation is used.
  always_comb begin
    div_sh   = {rem[DW-1:0], work[RES_W-1]};
    div_ge   = div_sh >= {1'b0, opb_r};
    div_rem  = div_ge ? div_sh - {1'b0, opb_r} : div_sh;
    mul_sum  = {1'b0, rem[MW-1:0]} + (work[0] ? {1'b0, opb_r[MW-1:0]} : {(MW+1){1'b0}});
    sq_sh    = {rem[RW-1:0], work[AW-1:AW-2]};
    sq_trial = {opb_r[RW-1:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;
  end

  always_comb begin
    unique case (op_r)
      pis_pkg::ALU_MUL:  cnt_last = CNT_W'(MW - 1);
      pis_pkg::ALU_DIV:  cnt_last = CNT_W'(RES_W - 1);
      pis_pkg::ALU_SQRT: cnt_last = CNT_W'(RW - 1);
      default:           cnt_last = '0;
    endcase
  end

  always_comb begin
    unique case (op_r)
      pis_pkg::ALU_MUL:  res = RES_W'({rem[MW-1:0], work[MW-1:0]});
      pis_pkg::ALU_DIV:  res = work;
      pis_pkg::ALU_SQRT: res = RES_W'(opb_r[RW-1:0]);
      default:           res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !ctl.start && (cnt == cnt_last);
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == cnt_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r  <= ctl.op;
      work  <= opa;
      rem   <= '0;
      opb_r <= opb;
    end else if (busy) begin
      case (op_r)
        pis_pkg::ALU_MUL: begin
          rem            <= (DW+1)'(mul_sum[MW:1]);
          work[MW-1:0]   <= {mul_sum[0], work[MW-1:1]};
        end
        pis_pkg::ALU_DIV: begin
          rem  <= div_rem;
          work <= {work[RES_W-2:0], div_ge};
        end
        pis_pkg::ALU_SQRT: begin
          rem   <= (DW+1)'(sq_rem);
          work  <= work << 2;
          opb_r <= DW'({opb_r[RW-2:0], sq_ge});
        end
        default: begin
          rem <= rem;
        end
      endcase
    end
  end

endmodule

FILE: rtl/packet_interarrival_stats.sv
// Keeps per-direction packet, byte and inter-arrival gap statistics and
// reports them on request. A packet record (tuser command 0) is taken while
// the block is idle and then passes through the gap, square and update steps
// before the next record is accepted. A report request (command 1)
// sends two transactions, outgoing then incoming, and clears the statistics.
// For a direction with more than two packets the mean, standard deviation
// and coefficient of variation come from one shared bit-serial unit: up to
// three divisions of 112+2*FRAC_BITS (at least 128) quotient bits, three
// 64-bit multiplies and a square root with a 56-bit result.
// A result waiting in the output register does not block packet records.
module packet_interarrival_stats #(
  parameter int TIME_BITS = 48,
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // timestamp_us[47:0], wire_length[63:48]
  input  logic [2:0]   s_tuser,   // command[0], direction[2:1]
  output logic         m_tvalid,
  input  logic         m_tready,
  // packet_count[47:0], byte_count[107:48], min_gap_us[155:108],
  // max_gap_us[203:156], mean_gap[259:204], std_gap[315:260], gap_cv[347:316],
  // stats_valid[348], gap_seen[349], ignored_count[397:350], zero[399:398]
  output logic [399:0] m_tdata,
  output logic         m_tuser,   // result_direction[0]
  output logic         m_tlast
);

  localparam int GAP_W = (TIME_BITS < 48) ? TIME_BITS : 48;
  localparam int NUM_W = pis_pkg::RAD_W + 2 * FRAC_BITS;
  localparam int RES_W = (NUM_W > 128) ? NUM_W : 128;
  localparam int DW    = pis_pkg::DEN_W;

  pis_pkg::pis_state_t state, state_next;
  logic                launch, launch_next;
  pis_pkg::alu_ctl_t   alu_ctl;
  logic [RES_W-1:0]    alu_opa;
  logic [DW-1:0]       alu_opb;
  logic                alu_done;
  logic [RES_W-1:0]    alu_res;

  // Statistics, one entry per direction.
  logic [47:0]      count_a  [2];
  logic [59:0]      bytes_a  [2];
  logic [63:0]      sum_a    [2];
  logic [63:0]      sqsum_a  [2];
  logic [GAP_W-1:0] min_a    [2];
  logic [GAP_W-1:0] max_a    [2];
  logic [1:0]       any_a;
  logic [47:0]      ignored;
  logic [GAP_W-1:0] prev_ts;
  logic             prev_valid;
  logic             dsel;

  // Packet record and report working registers.
  logic [1:0]       p_dir;
  logic [GAP_W-1:0] p_ts;
  logic [15:0]      p_len;
  logic [GAP_W-1:0] gap;
  logic             gap_ok;
  logic [63:0]      sq;
  logic [47:0]      n_reg;
  logic [127:0]     t1;
  logic [111:0]     dval;
  logic [DW-1:0]    nn;
  logic [111:0]     var_r;
  logic [55:0]      mean_r;
  logic [55:0]      std_r;
  logic [31:0]      cv_r;

  logic             idx;
  logic [47:0]      cur_count;
  logic [59:0]      cur_bytes;
  logic [63:0]      cur_sum;
  logic [63:0]      cur_sqsum;
  logic [GAP_W-1:0] cur_min;
  logic [GAP_W-1:0] cur_max;
  logic             cur_any;
  logic [48:0]      count_inc;
  logic [60:0]      bytes_inc;
  logic [64:0]      sum_inc;
  logic [64:0]      sqsum_inc;
  logic [48:0]      ign_inc;
  logic [63:0]      gap64;
  logic [31:0]      g32;
  logic [63:0]      sq_prod;
  logic [127:0]     ssq;
  logic             var_big;
  logic             out_free;
  logic             s_acc;

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign idx      = (state == pis_pkg::ST_ACC) ? p_dir[0] : dsel;

  always_comb begin
    cur_count = count_a[idx];
    cur_bytes = bytes_a[idx];
    cur_sum   = sum_a[idx];
    cur_sqsum = sqsum_a[idx];
    cur_min   = min_a[idx];
    cur_max   = max_a[idx];
    cur_any   = any_a[idx];
    count_inc = {1'b0, cur_count} + 49'd1;
    bytes_inc = {1'b0, cur_bytes} + 61'(p_len);
    sum_inc   = {1'b0, cur_sum} + 65'(gap);
    sqsum_inc = {1'b0, cur_sqsum} + {1'b0, sq};
    ign_inc   = {1'b0, ignored} + 49'd1;
    gap64     = 64'(gap);
    g32       = gap64[31:0];
    sq_prod   = g32 * g32;
    ssq       = alu_res[127:0];
    var_big   = |alu_res[RES_W-1:pis_pkg::RAD_W];
  end

  pis_alu #(
    .RES_W(RES_W)
  ) u_alu (
    .clk (clk),
    .rst (rst),
    .ctl (alu_ctl),
    .opa (alu_opa),
    .opb (alu_opb),
    .done(alu_done),
    .res (alu_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pis_pkg::ST_IDLE:  if (s_acc) begin
        state_next = s_tuser[0] ? pis_pkg::ST_CHECK : pis_pkg::ST_GAP;
      end
      pis_pkg::ST_GAP:   state_next = pis_pkg::ST_SQ;
      pis_pkg::ST_SQ:    state_next = pis_pkg::ST_ACC;
      pis_pkg::ST_ACC:   state_next = pis_pkg::ST_IDLE;
      pis_pkg::ST_CHECK: begin
        state_next = (cur_count > 48'd2) ? pis_pkg::ST_MEAN : pis_pkg::ST_EMIT;
      end
      pis_pkg::ST_MEAN:  if (alu_done) begin
        state_next = pis_pkg::ST_SUMSQ;
      end
      pis_pkg::ST_SUMSQ: if (alu_done) begin
        state_next = pis_pkg::ST_NSQ;
      end
      pis_pkg::ST_NSQ:   if (alu_done) begin
        state_next = pis_pkg::ST_NN;
      end
      pis_pkg::ST_NN:    if (alu_done) begin
        state_next = pis_pkg::ST_VAR;
      end
      pis_pkg::ST_VAR:   if (alu_done) begin
        if (!var_big) begin
          state_next = pis_pkg::ST_ROOT;
        end else begin
          state_next = (mean_r == '0) ? pis_pkg::ST_EMIT : pis_pkg::ST_CV;
        end
      end
      pis_pkg::ST_ROOT:  if (alu_done) begin
        state_next = (mean_r == '0) ? pis_pkg::ST_EMIT : pis_pkg::ST_CV;
      end
      pis_pkg::ST_CV:    if (alu_done) begin
        state_next = pis_pkg::ST_EMIT;
      end
      pis_pkg::ST_EMIT:  if (out_free) begin
        state_next = dsel ? pis_pkg::ST_IDLE : pis_pkg::ST_CHECK;
      end
      default:           state_next = pis_pkg::ST_IDLE;
    endcase
    launch_next = (state_next != state) &&
                  (state_next inside {pis_pkg::ST_MEAN, pis_pkg::ST_SUMSQ, pis_pkg::ST_NSQ,
                                      pis_pkg::ST_NN, pis_pkg::ST_VAR, pis_pkg::ST_ROOT,
                                      pis_pkg::ST_CV});
  end

  // Outputs toward the input channel and the arithmetic unit.
  always_comb begin
    s_tready      = (state == pis_pkg::ST_IDLE);
    alu_ctl.start = launch;
    alu_ctl.op    = pis_pkg::ALU_MUL;
    alu_opa       = '0;
    alu_opb       = '0;
    unique case (state)
      pis_pkg::ST_MEAN: begin
        alu_ctl.op = pis_pkg::ALU_DIV;
        alu_opa    = RES_W'(cur_sum) << FRAC_BITS;
        alu_opb    = DW'(n_reg);
      end
      pis_pkg::ST_SUMSQ: begin
        alu_opa = RES_W'(cur_sum);
        alu_opb = DW'(cur_sum);
      end
      pis_pkg::ST_NSQ: begin
        alu_opa = RES_W'(n_reg);
        alu_opb = DW'(cur_sqsum);
      end
      pis_pkg::ST_NN: begin
        alu_opa = RES_W'(n_reg);
        alu_opb = DW'(n_reg - 48'd1);
      end
      pis_pkg::ST_VAR: begin
        alu_ctl.op = pis_pkg::ALU_DIV;
        alu_opa    = RES_W'(dval) << (2 * FRAC_BITS);
        alu_opb    = nn;
      end
      pis_pkg::ST_ROOT: begin
        alu_ctl.op = pis_pkg::ALU_SQRT;
        alu_opa    = RES_W'(var_r);
      end
      pis_pkg::ST_CV: begin
        alu_ctl.op = pis_pkg::ALU_DIV;
        alu_opa    = RES_W'(std_r) << 16;
        alu_opb    = DW'(mean_r);
      end
      default: begin
        alu_ctl.op = pis_pkg::ALU_MUL;
      end
    endcase
  end

  // Control state and statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pis_pkg::ST_IDLE;
      launch     <= 1'b0;
      m_tvalid   <= 1'b0;
      dsel       <= 1'b0;
      prev_ts    <= '0;
      prev_valid <= 1'b0;
      ignored    <= '0;
      any_a      <= '0;
      for (int i = 0; i < 2; i++) begin
        count_a[i] <= '0;
        bytes_a[i] <= '0;
        sum_a[i]   <= '0;
        sqsum_a[i] <= '0;
        min_a[i]   <= '0;
        max_a[i]   <= '0;
      end
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if ((state == pis_pkg::ST_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        pis_pkg::ST_IDLE: begin
          dsel <= 1'b0;
        end
        pis_pkg::ST_GAP: begin
          prev_ts    <= p_ts;
          prev_valid <= 1'b1;
        end
        pis_pkg::ST_ACC: begin
          if (!p_dir[1]) begin
            count_a[idx] <= count_inc[48] ? '1 : count_inc[47:0];
            bytes_a[idx] <= bytes_inc[60] ? '1 : bytes_inc[59:0];
            if (gap_ok) begin
              sum_a[idx]   <= sum_inc[64] ? '1 : sum_inc[63:0];
              sqsum_a[idx] <= sqsum_inc[64] ? '1 : sqsum_inc[63:0];
              if (!cur_any || gap < cur_min) begin
                min_a[idx] <= gap;
              end
              if (!cur_any || gap > cur_max) begin
                max_a[idx] <= gap;
              end
              any_a[idx] <= 1'b1;
            end
          end else begin
            ignored <= ign_inc[48] ? '1 : ign_inc[47:0];
          end
        end
        pis_pkg::ST_EMIT: begin
          if (out_free) begin
            dsel <= 1'b1;
            if (dsel) begin
              ignored <= '0;
              any_a   <= '0;
              for (int i = 0; i < 2; i++) begin
                count_a[i] <= '0;
                bytes_a[i] <= '0;
                sum_a[i]   <= '0;
                sqsum_a[i] <= '0;
                min_a[i]   <= '0;
                max_a[i]   <= '0;
              end
            end
          end
        end
        default: begin
          dsel <= dsel;
        end
      endcase
    end
  end

  // Working registers and the output register payload.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      p_dir <= s_tuser[2:1];
      p_ts  <= s_tdata[GAP_W-1:0];
      p_len <= s_tdata[63:48];
    end
    case (state)
      pis_pkg::ST_GAP: begin
        gap    <= (p_ts >= prev_ts) ? p_ts - prev_ts : '0;
        gap_ok <= prev_valid;
      end
      pis_pkg::ST_SQ: begin
        sq <= (gap64 > 64'h0000_0000_FFFF_FFFF) ? '1 : sq_prod;
      end
      pis_pkg::ST_CHECK: begin
        n_reg  <= cur_count - 48'd1;
        mean_r <= '0;
        std_r  <= '0;
        cv_r   <= '0;
      end
      pis_pkg::ST_MEAN: if (alu_done) begin
        mean_r <= (|alu_res[RES_W-1:56]) ? '1 : alu_res[55:0];
      end
      pis_pkg::ST_SUMSQ: if (alu_done) begin
        t1 <= alu_res[127:0];
      end
      pis_pkg::ST_NSQ: if (alu_done) begin
        // A negative spread from rounding of saturated sums counts as zero.
        dval <= (ssq > t1) ? 112'(ssq - t1) : '0;
      end
      pis_pkg::ST_NN: if (alu_done) begin
        nn <= alu_res[DW-1:0];
      end
      pis_pkg::ST_VAR: if (alu_done) begin
        var_r <= alu_res[pis_pkg::RAD_W-1:0];
        if (var_big) begin
          std_r <= '1;
        end
      end
      pis_pkg::ST_ROOT: if (alu_done) begin
        std_r <= alu_res[55:0];
      end
      pis_pkg::ST_CV: if (alu_done) begin
        cv_r <= (|alu_res[RES_W-1:32]) ? '1 : alu_res[31:0];
      end
      pis_pkg::ST_EMIT: if (out_free) begin
        m_tdata <= {2'b00, ignored, cur_any, (cur_count > 48'd2), cv_r, std_r, mean_r,
                    (cur_any ? 48'(cur_max) : 48'd0), (cur_any ? 48'(cur_min) : 48'd0),
                    cur_bytes, cur_count};
        m_tuser <= dsel;
        m_tlast <= dsel;
      end
      default: begin
        gap_ok <= gap_ok;
      end
    endcase
  end

endmodule

FILE: tb/sv/packet_interarrival_stats_tb.sv
`timescale 1ns / 100ps

module packet_interarrival_stats_tb;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam logic [1:0] DIR_OUT = 2'd0;
  localparam logic [1:0] DIR_IN = 2'd1;
  localparam logic [1:0] DIR_UNK2 = 2'd2;
  localparam logic [1:0] DIR_UNK3 = 2'd3;
  localparam logic [47:0] MAX48 = '1;
  localparam logic [55:0] MAX56 = '1;
  localparam logic [59:0] MAX60 = '1;
  localparam logic [63:0] MAX64 = '1;
  localparam logic [31:0] MAX32 = '1;
  localparam int STALL_LIMIT = 10000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic        dir;
    logic [47:0] pkts;
    logic [59:0] bytes;
    logic [47:0] gmin;
    logic [47:0] gmax;
    logic [55:0] mean;
    logic [55:0] sdev;
    logic [31:0] cv;
    logic        sv;
    logic        seen;
    logic [47:0] ign;
    logic        last;
  } report_t;

  typedef struct {
    logic        cmd;
    logic [1:0]  dir;
    logic [47:0] ts;
    logic [15:0] len;
    logic        all_zero;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [399:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  packet_interarrival_stats dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Statistics as the block should hold them.
  logic [47:0] last_ts;
  logic        last_ts_ok;
  logic [47:0] pkt_cnt [2];
  logic [59:0] byte_cnt [2];
  logic [63:0] gsum [2];
  logic [63:0] gsq [2];
  logic [47:0] gmin [2];
  logic [47:0] gmax [2];
  logic        gany [2];
  logic [47:0] ign_cnt;

  report_t expected_reports[$];
  int fails = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;
  int quiet = 0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] maxv);
    if (a >= maxv || b > maxv - a) return maxv;
    return a + b;
  endfunction

  task automatic clear_stats();
    for (int d = 0; d < 2; d++) begin
      pkt_cnt[d] = '0; byte_cnt[d] = '0; gsum[d] = '0; gsq[d] = '0;
      gmin[d] = '0; gmax[d] = '0; gany[d] = 1'b0;
    end
    ign_cnt = '0;
  endtask

  task automatic derive_stats(int d, output logic [55:0] mean, output logic [55:0] sdev,
                              output logic [31:0] cv);
    logic [191:0] n, q, ssq, dsq, var_q, c2;
    logic [55:0] r, c;
    n = 192'(pkt_cnt[d]) - 192'd1;
    q = ({128'd0, gsum[d]} << 8) / n;
    mean = (q > MAX56) ? MAX56 : q[55:0];
    ssq = n * gsq[d];
    dsq = {128'd0, gsum[d]} * gsum[d];
    dsq = (ssq > dsq) ? ssq - dsq : '0;
    var_q = (dsq << 16) / (n * (n - 1));
    r = '0;
    if (var_q >= (192'd1 << 112)) begin
      r = MAX56;
    end else begin
      for (int b = 55; b >= 0; b--) begin
        c = r | (56'd1 << b);
        c2 = {136'd0, c} * c;
        if (c2 <= var_q) r = c;
      end
    end
    sdev = r;
    if (mean == 0) begin
      cv = '0;
    end else begin
      q = ({136'd0, r} << 16) / mean;
      cv = (q > MAX32) ? MAX32 : q[31:0];
    end
  endtask

  task automatic predict(logic cmd, logic [1:0] dir, logic [47:0] ts, logic [15:0] len,
                         logic all_zero);
    logic [47:0] gap;
    logic [63:0] sq;
    report_t rep;
    int d;
    if (cmd == CMD_PACKET) begin
      if (dir == DIR_OUT || dir == DIR_IN) begin
        d = dir;
        pkt_cnt[d] = 48'(sat_add(64'(pkt_cnt[d]), 64'd1, 64'(MAX48)));
        byte_cnt[d] = 60'(sat_add(64'(byte_cnt[d]), 64'(len), 64'(MAX60)));
        if (last_ts_ok) begin
          gap = (ts >= last_ts) ? ts - last_ts : '0;
          sq = (gap > MAX32) ? MAX64 : gap * gap;
          gsum[d] = sat_add(gsum[d], 64'(gap), MAX64);
          gsq[d] = sat_add(gsq[d], sq, MAX64);
          if (!gany[d] || gap < gmin[d]) gmin[d] = gap;
          if (!gany[d] || gap > gmax[d]) gmax[d] = gap;
          gany[d] = 1'b1;
        end
      end else begin
        ign_cnt = 48'(sat_add(64'(ign_cnt), 64'd1, 64'(MAX48)));
      end
      last_ts = ts;
      last_ts_ok = 1'b1;
    end else begin
      for (d = 0; d < 2; d++) begin
        rep.dir = d[0];
        rep.pkts = pkt_cnt[d];
        rep.bytes = byte_cnt[d];
        rep.gmin = gany[d] ? gmin[d] : '0;
        rep.gmax = gany[d] ? gmax[d] : '0;
        rep.sv = pkt_cnt[d] > 2;
        rep.mean = '0; rep.sdev = '0; rep.cv = '0;
        if (rep.sv) derive_stats(d, rep.mean, rep.sdev, rep.cv);
        rep.seen = gany[d];
        rep.ign = ign_cnt;
        rep.last = d[0];
        if (all_zero) begin
          // Right after reset or a report, every count and statistic reads zero.
          rep = '{d[0], '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, d[0]};
        end
        expected_reports.push_back(rep);
      end
      clear_stats();
    end
  endtask

  task automatic send(logic cmd, logic [1:0] dir, logic [47:0] ts, logic [15:0] len,
                      logic all_zero = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {len, ts};
    s_tuser <= {dir, cmd};
    do @(posedge clk); while (!s_tready);
    predict(cmd, dir, ts, len, all_zero);
    @(negedge clk);
  endtask

  task automatic chk(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    report_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report transaction");
        fails++;
      end else begin
        e = expected_reports.pop_front();
        chk("result_direction", e.dir, m_tuser);
        chk("packet_count", e.pkts, m_tdata[47:0]);
        chk("byte_count", e.bytes, m_tdata[107:48]);
        chk("min_gap_us", e.gmin, m_tdata[155:108]);
        chk("max_gap_us", e.gmax, m_tdata[203:156]);
        chk("mean_gap", e.mean, m_tdata[259:204]);
        chk("std_gap", e.sdev, m_tdata[315:260]);
        chk("gap_cv", e.cv, m_tdata[347:316]);
        chk("stats_valid", e.sv, m_tdata[348]);
        chk("gap_seen", e.seen, m_tdata[349]);
        chk("ignored_count", e.ign, m_tdata[397:350]);
        chk("last", e.last, m_tlast);
      end
    end
  end

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("packet_interarrival_stats_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  row_t directed [] = '{
    '{CMD_REPORT, DIR_OUT, 48'd0, 16'd0, 1'b1},
    '{CMD_PACKET, DIR_OUT, 48'd0, 16'd0, 1'b0},
    '{CMD_PACKET, DIR_IN, 48'd10, 16'hFFFF, 1'b0},
    '{CMD_PACKET, DIR_UNK2, 48'd5, 16'd64, 1'b0},
    '{CMD_PACKET, DIR_UNK3, MAX48, 16'd1500, 1'b0},
    '{CMD_PACKET, DIR_OUT, 48'd0, 16'd40, 1'b0},
    '{CMD_PACKET, DIR_OUT, 48'h1_0000_0000, 16'd100, 1'b0},
    '{CMD_PACKET, DIR_OUT, 48'h8000_0000_0000, 16'd9000, 1'b0},
    '{CMD_PACKET, DIR_IN, MAX48, 16'hAAAA, 1'b0},
    '{CMD_PACKET, DIR_IN, MAX48, 16'h5555, 1'b0},
    '{CMD_PACKET, DIR_IN, 48'd3, 16'd1, 1'b0},
    '{CMD_REPORT, DIR_IN, 48'd0, 16'd0, 1'b0},
    '{CMD_REPORT, DIR_OUT, 48'd0, 16'd0, 1'b1},
    '{CMD_PACKET, DIR_OUT, 48'd20, 16'd60, 1'b0},
    '{CMD_PACKET, DIR_OUT, 48'd20, 16'd60, 1'b0},
    '{CMD_PACKET, DIR_OUT, 48'd20, 16'd60, 1'b0},
    '{CMD_PACKET, DIR_IN, 48'd21, 16'd70, 1'b0},
    '{CMD_PACKET, DIR_IN, 48'd1021, 16'd70, 1'b0},
    '{CMD_PACKET, DIR_IN, 48'd1022, 16'd70, 1'b0},
    '{CMD_PACKET, DIR_IN, 48'd5000, 16'd70, 1'b0},
    '{CMD_REPORT, DIR_OUT, 48'd0, 16'd0, 1'b0}
  };

  task automatic random_items(int count);
    logic [47:0] ts;
    logic [1:0] dir;
    int sel;
    ts = last_ts;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(11) == 0) begin
        send(CMD_REPORT, 2'($urandom), 48'({$urandom, $urandom}), 16'($urandom));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) ts = ts + $urandom_range(2000);
        else if (sel < 85) ts = ts + $urandom_range(1 << 24);
        else if (sel < 90) ts = ts + 48'({$urandom, $urandom});
        else if (sel < 95) ts = ts - $urandom_range(500);
        else ts = 48'({$urandom, $urandom});
        sel = $urandom_range(99);
        dir = (sel < 45) ? DIR_OUT : (sel < 90) ? DIR_IN : 2'($urandom_range(2, 3));
        send(CMD_PACKET, dir, ts, 16'($urandom));
      end
    end
  endtask

  initial begin
    last_ts = '0;
    last_ts_ok = 1'b0;
    clear_stats();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send(directed[i].cmd, directed[i].dir, directed[i].ts, directed[i].len,
           directed[i].all_zero);
    idle_pct = 0; stall_pct = 0;
    random_items(250);
    idle_pct = 72; stall_pct = 0;
    random_items(200);
    idle_pct = 0; stall_pct = 72;
    random_items(200);
    idle_pct = 33; stall_pct = 33;
    random_items(200);
    // Long output hold-off: reports pile up and the input side backs up.
    idle_pct = 0; stall_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 4; i++) begin
      random_items(5);
      send(CMD_REPORT, DIR_OUT, '0, '0);
    end
    random_items(150);
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("packet_interarrival_stats_tb OK");
    end else begin
      $display("packet_interarrival_stats_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pis_pkg.sv
rtl/pis_alu.sv
rtl/packet_interarrival_stats.sv
tb/sv/packet_interarrival_stats_tb.sv
